/* rtl/c3d9_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package c3d9_pkg;

  // Field and register widths
  localparam int PIX_W     = 8;
  localparam int DIM_W     = 11;
  localparam int ROW_W     = 12;   // row counter runs up to height + 1
  localparam int KROW_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 16;   // 8 x 8 product
  localparam int RSUM_W    = 18;   // three products
  localparam int SUM_W     = 20;   // nine products

  // Depth of the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;

  // Register values after reset
  localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 11'd480;
  localparam logic [KROW_W-1:0] RST_KERNEL_ROW   = 24'h010101;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_KERNEL_TOP   = 3'd2,
    CFG_KERNEL_MID   = 3'd3,
    CFG_KERNEL_BOT   = 3'd4
  } cfg_idx_e;

  // Frame geometry as written
  typedef struct packed {
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] width;
  } frame_cfg_t;

  // Kernel rows, index 0 is the top row, left coefficient in the low byte
  typedef logic [2:0][KROW_W-1:0] kernel_t;

  // One window ready for the arithmetic, edge taps already zeroed.
  // pix index is row * 3 + column, row 0 at the top.
  typedef struct packed {
    logic                  last;
    logic [8:0][PIX_W-1:0] pix;
  } op_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

/* rtl/c3d9_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module c3d9_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire c3d9_pkg::frame_cfg_t   cfg_i,
  input  wire c3d9_pkg::queue_stat_t  q_stat_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   is_pixel_i,
  input  wire logic [7:0]             pixel_i,
  output logic                        push_o,
  output c3d9_pkg::op_t               op_o
);
  import c3d9_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (EW > DIM_W) ? EW : DIM_W;

  // Line buffer: upper byte is two rows above, lower byte one row above
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;

  logic [CW-1:0]          col_q, col_d;
  logic [ROW_W-1:0]       row_q, row_d;
  logic [8:0][PIX_W-1:0]  win_q, win_d;

  logic [XW-1:0]    fw_x;
  logic [EW-1:0]    w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [CW-1:0]    w_last;
  logic             accept;
  logic [PIX_W-1:0] pix_v;

  logic             col_nz;
  logic [ROW_W-1:0] row_off;
  logic [ROW_W-1:0] cr;
  logic [CW-1:0]    cc;
  logic             produce;
  logic             edge_top, edge_bot, edge_left, edge_right;
  logic [CW:0]      col_inc;
  logic [CW-1:0]    col_n;
  logic [ROW_W-1:0] row_n;

  // Effective frame size: zero acts as one, width capped at the buffer depth
  always_comb begin
    fw_x = XW'(cfg_i.width);
    if (cfg_i.width == '0) begin
      w_eff = EW'(1);
    end else if (fw_x > XW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(fw_x);
    end
    h_eff  = (cfg_i.height == '0) ? DIM_W'(1) : cfg_i.height;
    w_last = CW'(w_eff - EW'(1));
  end

  // Handshake: space in the queue is enough for any item
  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign pix_v      = is_pixel_i ? pixel_i : '0;

  // Which pixel this item completes, and where it sits in the frame
  always_comb begin
    col_nz     = (col_q != '0);
    row_off    = col_nz ? ROW_W'(1) : ROW_W'(2);
    cr         = row_q - row_off;
    cc         = col_nz ? (col_q - CW'(1)) : w_last;
    produce    = (row_q >= row_off) && (cr < ROW_W'(h_eff));
    edge_top   = (cr == '0);
    edge_bot   = (cr == (ROW_W'(h_eff) - ROW_W'(1)));
    edge_left  = (cc == '0);
    edge_right = (cc == w_last);
  end

  // Counter advance; the row after the flush ends the frame
  always_comb begin
    col_inc = {1'b0, col_q} + (CW+1)'(1);
    if (row_q >= (ROW_W'(h_eff) + ROW_W'(1))) begin
      col_n = '0;
      row_n = '0;
    end else if (col_inc >= (CW+1)'(w_eff)) begin
      col_n = '0;
      row_n = row_q + ROW_W'(1);
    end else begin
      col_n = col_inc[CW-1:0];
      row_n = row_q;
    end
    col_d = accept ? col_n : col_q;
    row_d = accept ? row_n : row_q;
  end

  // Window shift, new column from the line buffer and the input
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3+0] = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = rd_q[2*PIX_W-1:PIX_W];
    win_d[5] = rd_q[PIX_W-1:0];
    win_d[8] = pix_v;
  end

  // Zero the taps that fall outside the frame
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && edge_top) || (r == 2 && edge_bot) ||
            (c == 0 && edge_left) || (c == 2 && edge_right)) begin
          op_o.pix[r*3+c] = '0;
        end else begin
          op_o.pix[r*3+c] = win_d[r*3+c];
        end
      end
    end
    op_o.last = edge_bot && edge_right;
  end

  assign push_o = accept && produce;

  // Position and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      win_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        win_q <= win_d;
      end
    end
  end

  // Line buffer: read one column ahead, bypass a write to the same column
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem[col_q] <= {rd_q[PIX_W-1:0], pix_v};
    end
    if (accept && (col_d == col_q)) begin
      rd_q <= {rd_q[PIX_W-1:0], pix_v};
    end else begin
      rd_q <= line_mem[col_d];
    end
  end

endmodule

`default_nettype wire

/* rtl/c3d9_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module c3d9_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire c3d9_pkg::op_t          op_i,
  input  wire logic                   pop_i,
  output c3d9_pkg::op_t               op_o,
  output c3d9_pkg::queue_stat_t       stat_o
);
  import c3d9_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  op_t           entry_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW:0]   cnt_q, cnt_d;

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = push_i ? (wr_ptr_q + AW'(1)) : wr_ptr_q;
    rd_ptr_d = pop_i  ? (rd_ptr_q + AW'(1)) : rd_ptr_q;
    cnt_d    = cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
  end

  assign stat_o.full  = (cnt_q == (AW+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign op_o         = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/c3d9_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module c3d9_back #(
  parameter int DIVISOR = 9
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire c3d9_pkg::kernel_t      kernel_i,
  input  wire c3d9_pkg::queue_stat_t  q_stat_i,
  input  wire c3d9_pkg::op_t          op_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [7:0]                  out_data_o,
  output logic                        out_last_o
);
  import c3d9_pkg::*;

  // Exact reciprocal for numerators below 2^16: m = ceil(2^(16+l) / d)
  localparam int                 NUM_W      = 16;
  localparam int                 DIV_L      = $clog2(DIVISOR);
  localparam int                 DIV_K      = NUM_W + DIV_L;
  localparam int                 RECIP_W    = NUM_W + 1;
  localparam int                 MUL_W      = NUM_W + RECIP_W;
  localparam logic [63:0]        RECIP_FULL =
      ((64'd1 << DIV_K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(RECIP_FULL);
  localparam logic [SUM_W-1:0]   SAT_LIMIT  = SUM_W'(256 * DIVISOR);

  logic en_p, en_r, en_s, en_o;

  logic                   p_v_q, p_last_q;
  logic [8:0][PROD_W-1:0] prod_q, prod_d;
  logic                   r_v_q, r_last_q;
  logic [2:0][RSUM_W-1:0] rsum_q, rsum_d;
  logic                   s_v_q, s_last_q, sat_q, sat_d;
  logic [NUM_W-1:0]       sum_q;
  logic [SUM_W-1:0]       total;
  logic [MUL_W-1:0]       quot_full;
  logic                   o_v_q, o_last_q;
  logic [PIX_W-1:0]       out_q, out_d;

  // Stage advance, from the output backwards
  assign en_o  = !o_v_q || out_ready_i;
  assign en_s  = !s_v_q || en_o;
  assign en_r  = !r_v_q || en_s;
  assign en_p  = !p_v_q || en_r;
  assign pop_o = !q_stat_i.empty && en_p;

  // Products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r*3+c] = PROD_W'(op_i.pix[r*3+c]) * PROD_W'(kernel_i[r][8*c +: 8]);
      end
    end
  end

  // Row sums
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum_d[r] = RSUM_W'(prod_q[r*3]) + RSUM_W'(prod_q[r*3+1]) + RSUM_W'(prod_q[r*3+2]);
    end
  end

  // Total and saturation check
  always_comb begin
    total = SUM_W'(rsum_q[0]) + SUM_W'(rsum_q[1]) + SUM_W'(rsum_q[2]);
    sat_d = (total >= SAT_LIMIT);
  end

  // Quotient by reciprocal multiply
  always_comb begin
    quot_full = MUL_W'(sum_q) * MUL_W'(RECIP);
    out_d     = sat_q ? {PIX_W{1'b1}} : quot_full[DIV_K +: PIX_W];
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
      r_v_q <= 1'b0;
      s_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (en_p) p_v_q <= pop_o;
      if (en_r) r_v_q <= p_v_q;
      if (en_s) s_v_q <= r_v_q;
      if (en_o) o_v_q <= s_v_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (en_p) begin
      prod_q   <= prod_d;
      p_last_q <= op_i.last;
    end
    if (en_r) begin
      rsum_q   <= rsum_d;
      r_last_q <= p_last_q;
    end
    if (en_s) begin
      sum_q    <= total[NUM_W-1:0];
      sat_q    <= sat_d;
      s_last_q <= r_last_q;
    end
    if (en_o) begin
      out_q    <= out_d;
      o_last_q <= s_last_q;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_data_o  = out_q;
  assign out_last_o  = o_last_q;

endmodule

`default_nettype wire

/* rtl/conv3x3_zero_pad_div9_unit.sv */
// 3x3 correlation with zero padding, sum divided by DIVISOR and saturated to 255.
// Throughput: one pixel or flush transaction per cycle while the queue is not full; the line
// buffer is read one column ahead. A result passes the queue, products, row sums, total and
// quotient registers; the transaction that completes its window comes W+1 items after its pixel.
// Reset: counters, window and queue cleared, registers to 640x480 with all-ones kernel;
// line buffers are not cleared (frame-edge masking hides them), so no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module conv3x3_zero_pad_div9_unit #(
  parameter int MAX_WIDTH = 1024,
  parameter int DIVISOR   = 9
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [c3d9_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [c3d9_pkg::KROW_W-1:0]     cfg_data_i,
  // Input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,   // [7:0] pixel
  input  wire logic                            s_axis_tuser,   // [0] is_pixel
  // Output stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [7:0]                           m_axis_tdata,   // [7:0] filtered
  output logic                                 m_axis_tlast    // frame_end
);
  import c3d9_pkg::*;

  frame_cfg_t  frame_cfg_q;
  kernel_t     kernel_q;
  queue_stat_t q_stat;
  op_t         push_op, pop_op;
  logic        q_push, q_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cfg_q.width  <= RST_FRAME_WIDTH;
      frame_cfg_q.height <= RST_FRAME_HEIGHT;
      kernel_q           <= {3{RST_KERNEL_ROW}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_cfg_q.width  <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT: frame_cfg_q.height <= cfg_data_i[DIM_W-1:0];
        CFG_KERNEL_TOP:   kernel_q[0]        <= cfg_data_i;
        CFG_KERNEL_MID:   kernel_q[1]        <= cfg_data_i;
        CFG_KERNEL_BOT:   kernel_q[2]        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: position tracking, line buffers, window
  c3d9_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (frame_cfg_q),
    .q_stat_i   (q_stat),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .is_pixel_i (s_axis_tuser),
    .pixel_i    (s_axis_tdata),
    .push_o     (q_push),
    .op_o       (push_op)
  );

  // Queue between front and back
  c3d9_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .op_i   (push_op),
    .pop_i  (q_pop),
    .op_o   (pop_op),
    .stat_o (q_stat)
  );

  // Back: multiply, sum, divide, output register
  c3d9_back #(
    .DIVISOR (DIVISOR)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kernel_i    (kernel_q),
    .q_stat_i    (q_stat),
    .op_i        (pop_op),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // Queue never written while full
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
      q_push |-> !q_stat.full)
    else $error("window pushed into full queue");

  // Queue never read while empty
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
      q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // A push without a pop leaves the queue occupied
  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (q_push && !q_pop) |=> !q_stat.empty)
    else $error("pushed window lost");

endmodule

`default_nettype wire

/* sim/tb_conv3x3_zero_pad_div9_unit.sv */
`timescale 1ns / 1ps

module tb_conv3x3_zero_pad_div9_unit;
  import c3d9_pkg::*;

  localparam int LINE_DEPTH    = 1024;   // line buffer depth of the instance
  localparam int DIV           = 9;
  localparam int RANDOM_ITEMS  = 100;
  localparam int SETTLE_CYCLES = 10;     // pipeline depth plus margin
  localparam int DRAIN_CYCLES  = 16;
  localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
  localparam int STALL_LIMIT   = 4000;   // cycles without any transaction

  // One output pixel as the block should deliver it
  typedef struct packed {
    logic [PIX_W-1:0] filtered;
    logic             frame_end;
  } px_result_t;

  // Line-buffer and window predictor plus the queue of pixels still due
  class filter_scoreboard;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [KROW_W-1:0] krow [3];
    logic [PIX_W-1:0]  line_up1 [LINE_DEPTH];
    logic [PIX_W-1:0]  line_up2 [LINE_DEPTH];
    logic [PIX_W-1:0]  win [3][3];
    int unsigned       col;
    int unsigned       row;
    px_result_t        expected_pixels [$];
    int                errors;
    int                n_in;
    int                n_out;
    int                n_ends;

    function void clear();
      width_reg  = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      foreach (krow[i]) krow[i] = RST_KERNEL_ROW;
      foreach (line_up1[i]) begin
        line_up1[i] = '0;
        line_up2[i] = '0;
      end
      foreach (win[r, c]) win[r][c] = '0;
      col = 0;
      row = 0;
      expected_pixels.delete();
      errors = 0;
      n_in   = 0;
      n_out  = 0;
      n_ends = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [KROW_W-1:0] val);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg  = val[DIM_W-1:0];
        CFG_FRAME_HEIGHT: height_reg = val[DIM_W-1:0];
        CFG_KERNEL_TOP:   krow[0]    = val;
        CFG_KERNEL_MID:   krow[1]    = val;
        CFG_KERNEL_BOT:   krow[2]    = val;
        default: ;
      endcase
    endfunction

    // Advance the window by one accepted transaction, queue the pixel it completes
    function void note_pixel_in(logic is_pix, logic [PIX_W-1:0] pix);
      int unsigned w, h, idx, sum, q, coef;
      int          cr, cc;
      logic [PIX_W-1:0] v;
      px_result_t  res;
      n_in++;
      w = (width_reg == 0) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
      h = (height_reg == 0) ? 1 : height_reg;
      v = is_pix ? pix : '0;
      idx = col % LINE_DEPTH;
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = line_up2[idx];
      win[1][2] = line_up1[idx];
      win[2][2] = v;
      line_up2[idx] = line_up1[idx];
      line_up1[idx] = v;

      // column 0 finishes the last pixel of the row two above
      if (col >= 1) begin
        cr = int'(row) - 1;
        cc = int'(col) - 1;
      end else begin
        cr = int'(row) - 2;
        cc = int'(w) - 1;
      end

      if (cr >= 0 && cr < int'(h)) begin
        sum = 0;
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            // taps outside the frame count as zero
            if (!((r == 0 && cr == 0) || (r == 2 && cr == int'(h) - 1) ||
                  (c == 0 && cc == 0) || (c == 2 && cc == int'(w) - 1))) begin
              coef = krow[r][8*c +: 8];
              sum += win[r][c] * coef;
            end
          end
        end
        q = sum / DIV;
        if (q > 255) q = 255;
        res.filtered  = q[PIX_W-1:0];
        res.frame_end = (cr == int'(h) - 1) && (cc == int'(w) - 1);
        expected_pixels.push_back(res);
      end

      if (row >= h + 1) begin
        row = 0;
        col = 0;
      end else begin
        col++;
        if (col >= w) begin
          col = 0;
          row++;
        end
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      errors++;
    endtask

    task check_filtered(logic [PIX_W-1:0] filtered, logic frame_end);
      px_result_t exp_px;
      n_out++;
      if (frame_end) n_ends++;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected output %0d (tlast %0b)", filtered, frame_end));
      end else begin
        exp_px = expected_pixels.pop_front();
        if (filtered !== exp_px.filtered)
          report_mismatch($sformatf("output #%0d filtered %0d, expected %0d",
                                    n_out, filtered, exp_px.filtered));
        if (frame_end !== exp_px.frame_end)
          report_mismatch($sformatf("output #%0d tlast %0b, expected %0b",
                                    n_out, frame_end, exp_px.frame_end));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [KROW_W-1:0]    cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;
  logic                 m_axis_tlast;

  filter_scoreboard sb;
  bit gaps_on;
  bit stalls_on;
  bit hold_req;
  int pix_mode;
  int items_sent;
  int frames_sent;

  conv3x3_zero_pad_div9_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Monitor: inputs feed the predictor, outputs are checked
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_pixel_in(s_axis_tuser, s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_filtered(m_axis_tdata, m_axis_tlast);
  end

  // Watchdog on cycles without any transaction
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          cfg_we_i || !rst_ni)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[%0t] timeout: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("conv3x3_zero_pad_div9_unit verification failed");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin : receiver
    int stall_left;
    int pick;
    stall_left = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left == 0 && stalls_on) begin
        pick = $urandom_range(0, 99);
        if (pick < 20)      stall_left = $urandom_range(1, 3);
        else if (pick < 24) stall_left = $urandom_range(8, 40);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int pick;
    if (!gaps_on) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_pixel();
    case (pix_mode)
      1:       return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'hFF;
      2:       return 8'($urandom_range(0, 15));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [KROW_W-1:0] pick_kernel_row();
    case ($urandom_range(0, 5))
      0:       return 24'hFFFFFF;
      1:       return RST_KERNEL_ROW;
      2:       return {6'd0, 2'($urandom), 6'd0, 2'($urandom), 6'd0, 2'($urandom)};
      default: return KROW_W'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic is_pix, input logic [7:0] pix);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= is_pix;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Frame pixels; now and then an item flagged as not a pixel
  task automatic send_pixels(input int n);
    repeat (n) send_item($urandom_range(0, 15) != 0, pick_pixel());
  endtask

  // Flush items; some carry a pixel flag and a value, which must not matter
  task automatic send_flush(input int n);
    repeat (n) send_item($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_frame(input int w, input int h);
    send_pixels(w * h);
    send_flush(w + 1);
    frames_sent++;
  endtask

  // Stop offering, wait for every due pixel, then let the pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // One register write per cycle; the caller lowers the enable after a batch
  task automatic put_reg(input cfg_idx_e idx, input logic [KROW_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic set_frame(input int w, input int h, input logic [KROW_W-1:0] top,
                           input logic [KROW_W-1:0] mid, input logic [KROW_W-1:0] bot);
    put_reg(CFG_FRAME_WIDTH, KROW_W'(w));
    put_reg(CFG_FRAME_HEIGHT, KROW_W'(h));
    put_reg(CFG_KERNEL_TOP, top);
    put_reg(CFG_KERNEL_MID, mid);
    put_reg(CFG_KERNEL_BOT, bot);
    cfg_we_i <= 1'b0;
  endtask

  task automatic shuffle_idling();
    gaps_on   = ($urandom_range(0, 3) != 0);
    stalls_on = ($urandom_range(0, 3) != 0);
  endtask

  initial begin : stimulus
    int w, h, start_items;
    sb = new();
    sb.clear();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    gaps_on       = 1'b0;
    stalls_on     = 1'b0;
    hold_req      = 1'b0;
    pix_mode      = 0;
    items_sent    = 0;
    frames_sent   = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset width and kernel: only the height is written, one 640-pixel row
    put_reg(CFG_FRAME_HEIGHT, KROW_W'(1));
    cfg_we_i <= 1'b0;
    shuffle_idling();
    send_frame(640, 1);
    settle();

    // Zero size acts as 1x1; full kernel with white pixels saturates
    set_frame(0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    pix_mode = 1;
    send_frame(1, 1);
    settle();

    // Smallest legal size, all-zero kernel
    set_frame(1, 1, 24'h000000, 24'h000000, 24'h000000);
    send_frame(1, 1);
    settle();

    // Saturation over a full 3x3 frame
    set_frame(3, 3, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_frame(3, 3);
    settle();

    // Distinct coefficients expose any flip or row swap
    set_frame(4, 3, 24'h030201, 24'h060504, 24'h090807);
    pix_mode = 0;
    shuffle_idling();
    send_frame(4, 3);
    settle();

    // Size change mid-frame: 8x6 shrinks to 5x5 with the column already past 5
    set_frame(8, 6, pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
    send_pixels(3 * 8 + 6);
    settle();
    put_reg(CFG_FRAME_WIDTH, KROW_W'(5));
    put_reg(CFG_FRAME_HEIGHT, KROW_W'(5));
    cfg_we_i <= 1'b0;
    send_pixels(1 + 5);
    send_flush(5 + 1);
    frames_sent++;
    settle();

    // Random frames; the first runs against a long output hold-off
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) w = $urandom_range(13, 40);
      else                           w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      pix_mode = $urandom_range(0, 3);
      set_frame(w, h, pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
      if (start_items == items_sent) begin
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        w = 12;
        h = 8;
        set_frame(w, h, pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
      end else begin
        shuffle_idling();
      end
      send_frame(w, h);
      settle();
    end

    // Drain and finish
    s_axis_tvalid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.expected_pixels.size() != 0)
      sb.report_mismatch($sformatf("%0d outputs never arrived", sb.expected_pixels.size()));
    $display("Run covered %0d input transactions in %0d frames, %0d outputs checked, %0d ends.",
             sb.n_in, frames_sent, sb.n_out, sb.n_ends);
    $display("Sizes 1x1 up to a 640-pixel reset-width row, saturation, a mid-frame resize.");
    if (sb.errors == 0) begin
      $display("conv3x3_zero_pad_div9_unit verification clean");
    end else begin
      $display("conv3x3_zero_pad_div9_unit verification failed");
    end
    $finish;
  end

endmodule
